FILE: rtl/core/arpc_pkg.sv
// Shared types and constants for the ARP cache with pending request table.
// No dependencies.
package arpc_pkg;
    localparam int CACHE_DEPTH   = 16;
    localparam int PENDING_DEPTH = 16;
    localparam int PORT_BITS     = 4;
    localparam int CIDX_W = $clog2(CACHE_DEPTH);
    localparam int PIDX_W = $clog2(PENDING_DEPTH);
    localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
    localparam logic [7:0] SENDS_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ACT_LOOKUP = 3'd0, ACT_INSERT = 3'd1, ACT_QUEUE = 3'd2,
        ACT_REMOVE = 3'd3, ACT_TICK = 3'd4, ACT_CLEAR = 3'd5,
        ACT_RSV6 = 3'd6, ACT_RSV7 = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        KIND_LOOKUP = 3'd0, KIND_INSERT = 3'd1, KIND_QUEUE = 3'd2,
        KIND_SEND = 3'd3, KIND_DONE = 3'd4
    } t_kind;

    localparam logic [0:0] REG_TIMEOUT   = 1'b0;
    localparam logic [0:0] REG_MAX_SENDS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_SWEEP, ST_SEND, ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic               exec;      // run the action on the latched item
        logic               sweep;     // scan pending slot pidx; age the cache when pidx is zero
        logic [PIDX_W-1:0]  pidx;
        logic               send;      // emit send order for pidx
        logic               done;      // emit done beat
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pend_live;   // pending slot pidx valid and below send limit
    } t_stat;
endpackage

FILE: rtl/core/arpc_ctrl.sv
// Controller for the ARP cache: sequences actions and the tick walk.
// Depends on arpc_pkg.
module arpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_action,
    input  arpc_pkg::t_stat  i_stat,
    output arpc_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import arpc_pkg::*;

    t_state r_state, n_state;
    logic [PIDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.pidx = r_idx;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_idx = '0;
                    n_state = (t_action'(i_action) == ACT_TICK) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.pend_live) begin
                    n_state = ST_SEND;
                end else if (32'(r_idx) == PENDING_DEPTH - 1) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_SEND: begin
                o_cmd.send = 1'b1;
                if (32'(r_idx) == PENDING_DEPTH - 1) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_SWEEP;
                end
            end
            ST_DONE: begin
                o_cmd.done = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/arpc_dp.sv
// Datapath for the ARP cache: both tables, config registers, result register.
// Depends on arpc_pkg.
module arpc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [2:0]            i_action,
    input  logic [31:0]           i_ip_addr,
    input  logic [47:0]           i_mac_addr,
    input  logic [3:0]            i_port_index,
    input  logic [3:0]            i_request_slot,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  arpc_pkg::t_cmd        i_cmd,
    output arpc_pkg::t_stat       o_stat,
    output logic                  o_valid,
    output logic [2:0]            o_kind,
    output logic                  o_hit,
    output logic [47:0]           o_found_mac,
    output logic [3:0]            o_slot,
    output logic                  o_full_res,
    output logic [31:0]           o_target_ip,
    output logic [3:0]            o_send_port,
    output logic                  o_last
);
    import arpc_pkg::*;

    logic [15:0] r_timeout;
    logic [7:0]  r_max_sends;
    logic [2:0]  r_act;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [PORT_BITS-1:0] r_port;
    logic [3:0]  r_rslot;

    logic [CACHE_DEPTH-1:0]   r_ev;
    logic [31:0]              r_eip  [CACHE_DEPTH];
    logic [47:0]              r_emac [CACHE_DEPTH];
    logic [15:0]              r_eage [CACHE_DEPTH];
    logic [PENDING_DEPTH-1:0] r_pv;
    logic [31:0]              r_pip  [PENDING_DEPTH];
    logic [PORT_BITS-1:0]     r_pport[PENDING_DEPTH];
    logic [7:0]               r_psend[PENDING_DEPTH];

    // priority searches over the tables (independent compares)
    logic              e_hit, e_free_ok, p_hit, p_free_ok;
    logic [CIDX_W-1:0] e_hit_idx, e_free_idx;
    logic [PIDX_W-1:0] p_hit_idx, p_free_idx;
    always_comb begin
        e_hit = 1'b0; e_hit_idx = '0; e_free_ok = 1'b0; e_free_idx = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            if (r_ev[i] && r_eip[i] == r_ip) begin
                e_hit = 1'b1; e_hit_idx = CIDX_W'(i);
            end
            if (!r_ev[i]) begin
                e_free_ok = 1'b1; e_free_idx = CIDX_W'(i);
            end
        end
        p_hit = 1'b0; p_hit_idx = '0; p_free_ok = 1'b0; p_free_idx = '0;
        for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
            if (r_pv[i] && r_pip[i] == r_ip) begin
                p_hit = 1'b1; p_hit_idx = PIDX_W'(i);
            end
            if (!r_pv[i]) begin
                p_free_ok = 1'b1; p_free_idx = PIDX_W'(i);
            end
        end
    end

    assign o_stat.pend_live = r_pv[i_cmd.pidx] && (r_psend[i_cmd.pidx] < r_max_sends);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= 16'd30;
            r_max_sends <= 8'd5;
            r_ev  <= '0;
            r_pv  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TIMEOUT) r_timeout <= i_cfg_data;
                else r_max_sends <= i_cfg_data[7:0];
            end
            o_valid <= 1'b0;
            if (i_cmd.exec) begin
                o_valid <= 1'b1;
                unique case (t_action'(r_act))
                    ACT_INSERT: if (e_free_ok) r_ev[e_free_idx] <= 1'b1;
                    ACT_QUEUE: if (!p_hit && p_free_ok) r_pv[p_free_idx] <= 1'b1;
                    ACT_REMOVE: if (32'(r_rslot) < PENDING_DEPTH)
                        r_pv[PIDX_W'(r_rslot)] <= 1'b0;
                    ACT_CLEAR: begin
                        r_ev <= '0;
                        r_pv <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.sweep) begin
                // age the whole cache on the first step of the walk
                if (i_cmd.pidx == '0) begin
                    for (int i = 0; i < CACHE_DEPTH; i++) begin
                        if (r_ev[i] && ((r_eage[i] == 16'hFFFF ? r_eage[i]
                                : r_eage[i] + 16'd1) > r_timeout))
                            r_ev[i] <= 1'b0;
                    end
                end
                if (r_pv[i_cmd.pidx] && !o_stat.pend_live) r_pv[i_cmd.pidx] <= 1'b0;
            end
            if (i_cmd.send || i_cmd.done) o_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_act   <= i_action;
            r_ip    <= i_ip_addr;
            r_mac   <= i_mac_addr;
            r_port  <= i_port_index[PORT_BITS-1:0];
            r_rslot <= i_request_slot;
        end
        if (i_cmd.exec && t_action'(r_act) == ACT_INSERT && e_free_ok) begin
            r_eip[e_free_idx]  <= r_ip;
            r_emac[e_free_idx] <= r_mac;
            r_eage[e_free_idx] <= '0;
        end
        if (i_cmd.exec && t_action'(r_act) == ACT_QUEUE && !p_hit && p_free_ok) begin
            r_pip[p_free_idx]   <= r_ip;
            r_pport[p_free_idx] <= r_port;
            r_psend[p_free_idx] <= '0;
        end
        if (i_cmd.sweep && i_cmd.pidx == '0) begin
            for (int i = 0; i < CACHE_DEPTH; i++)
                if (r_ev[i] && r_eage[i] != 16'hFFFF) r_eage[i] <= r_eage[i] + 16'd1;
        end
        if (i_cmd.send) r_psend[i_cmd.pidx] <= r_psend[i_cmd.pidx] + 8'd1;

        o_kind <= KIND_DONE; o_hit <= 1'b0; o_found_mac <= '0; o_slot <= '0;
        o_full_res <= 1'b0; o_target_ip <= '0; o_send_port <= '0; o_last <= 1'b1;
        if (i_cmd.exec) begin
            unique case (t_action'(r_act))
                ACT_LOOKUP: begin
                    o_kind <= KIND_LOOKUP;
                    o_hit  <= e_hit;
                    o_found_mac <= e_hit ? r_emac[e_hit_idx] : 48'd0;
                end
                ACT_INSERT: begin
                    o_kind <= KIND_INSERT;
                    o_hit  <= p_hit;
                    o_slot <= 4'(p_hit_idx);
                    o_full_res <= !e_free_ok;
                end
                ACT_QUEUE: begin
                    o_kind <= KIND_QUEUE;
                    o_slot <= p_hit ? 4'(p_hit_idx) : (p_free_ok ? 4'(p_free_idx) : 4'd0);
                    o_full_res <= !p_hit && !p_free_ok;
                end
                default: ;
            endcase
        end
        if (i_cmd.send) begin
            o_kind <= KIND_SEND;
            o_slot <= 4'(i_cmd.pidx);
            o_target_ip <= r_pip[i_cmd.pidx];
            o_send_port <= 4'(r_pport[i_cmd.pidx]);
            o_last <= 1'b0;
        end
    end
endmodule

FILE: rtl/core/arp_cache_with_retry_table.sv
// ARP cache with pending request table: top level.
// Lookup, insert, queue pass through ST_EXEC to a registered result; remove, clear to a done result.
// Tick: walks the pending table, a sweep step per slot plus a send step per send order,
//   then done. The next item is taken once busy drops.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset empties both tables and reloads register defaults.
module arp_cache_with_retry_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_ip_addr,
    input  logic [47:0] i_mac_addr,
    input  logic [3:0]  i_port_index,
    input  logic [3:0]  i_request_slot,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic        o_hit,
    output logic [47:0] o_found_mac,
    output logic [3:0]  o_slot,
    output logic        o_full_res,
    output logic [31:0] o_target_ip,
    output logic [3:0]  o_send_port,
    output logic        o_last
);
    import arpc_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  load;

    assign load = start && !busy;

    arpc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_action(i_action),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    arpc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load), .i_action(i_action),
        .i_ip_addr(i_ip_addr), .i_mac_addr(i_mac_addr), .i_port_index(i_port_index),
        .i_request_slot(i_request_slot), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_cmd(cmd), .o_stat(stat), .o_valid(o_valid),
        .o_kind(o_kind), .o_hit(o_hit), .o_found_mac(o_found_mac), .o_slot(o_slot),
        .o_full_res(o_full_res), .o_target_ip(o_target_ip), .o_send_port(o_send_port),
        .o_last(o_last)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.exec, cmd.sweep, cmd.send, cmd.done}) <= 1)
        else $error("controller issued overlapping commands");
    a_send_after_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.send |-> $past(cmd.sweep && stat.pend_live))
        else $error("send order without a live pending slot");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.done |=> (o_valid && o_last))
        else $error("done beat not marked last");
endmodule
